/* src/vau_pkg.sv */
// ----------------------------------------------------------------------------
// vau_pkg: shared definitions of the vector arithmetic unit
// Request codes, lane operation codes, widths and pipeline latencies.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int LANES         = 3;
  localparam int RAD_W         = 2 * DATA_W;
  localparam int DIV_STEPS     = DATA_W;

  localparam int LANE_LAT = 2;
  localparam int SUM_LAT  = 2;
  localparam int SQRT_LAT = DATA_W;
  localparam int DIV_LAT  = DIV_STEPS + 2;

  localparam int SQ_AT  = LANE_LAT + SUM_LAT + SQRT_LAT - 1;
  localparam int DIV_AT = SQ_AT + DIV_LAT;
  localparam int REC_N  = DIV_AT + 1;

  typedef enum logic [3:0] {
    REQ_VADD = 4'd0,
    REQ_VSUB = 4'd1,
    REQ_VMUL = 4'd2,
    REQ_VDIV = 4'd3,
    REQ_SADD = 4'd4,
    REQ_SSUB = 4'd5,
    REQ_SMUL = 4'd6,
    REQ_SDIV = 4'd7,
    REQ_EQ   = 4'd8,
    REQ_NE   = 4'd9,
    REQ_MAG  = 4'd10,
    REQ_NORM = 4'd11
  } req_t;

  typedef enum logic [1:0] {
    LOP_ADD,
    LOP_SUB,
    LOP_MUL
  } lane_op_t;

  typedef struct packed {
    logic sat;
    logic dz;
  } div_flags_t;

endpackage

/* src/vau_lane.sv */
// ----------------------------------------------------------------------------
// vau_lane: one component lane
// Saturating add, subtract and fixed-point multiply of one vector component.
// The raw product is also passed on for the sum of squares.
// ----------------------------------------------------------------------------
module vau_lane
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  lane_op_t                   kind,
  input  logic signed [DATA_W-1:0]   a,
  input  logic signed [DATA_W-1:0]   opnd,
  output logic signed [DATA_W-1:0]   res,
  output logic                       sat,
  output logic        [2*DATA_W-1:0] prod
);

  localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

  lane_op_t                   kind_r;
  logic        [DATA_W:0]     add_r;
  logic signed [2*DATA_W-1:0] mul_r;
  logic signed [2*DATA_W-1:0] shifted;
  logic                       mul_ovf;
  logic                       add_ovf;
  logic        [DATA_W-1:0]   res_nxt;
  logic                       sat_nxt;
  logic        [DATA_W-1:0]   res_r;
  logic                       sat_r;
  logic        [2*DATA_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    kind_r <= kind;
    if (kind == LOP_SUB) begin
      add_r <= {a[DATA_W-1], a} - {opnd[DATA_W-1], opnd};
    end else begin
      add_r <= {a[DATA_W-1], a} + {opnd[DATA_W-1], opnd};
    end
    mul_r <= (2*DATA_W)'(a) * (2*DATA_W)'(opnd);
  end

  always_comb begin
    shifted = mul_r >>> FRAC_BITS;
    mul_ovf = !((&shifted[2*DATA_W-1:DATA_W-1]) || (~|shifted[2*DATA_W-1:DATA_W-1]));
    add_ovf = add_r[DATA_W] ^ add_r[DATA_W-1];
    if (kind_r == LOP_MUL) begin
      sat_nxt = mul_ovf;
      res_nxt = mul_ovf ? (shifted[2*DATA_W-1] ? MINV : MAXV) : shifted[DATA_W-1:0];
    end else begin
      sat_nxt = add_ovf;
      res_nxt = add_ovf ? (add_r[DATA_W] ? MINV : MAXV) : add_r[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    sat_r  <= sat_nxt;
    prod_r <= mul_r;
  end

  assign res  = res_r;
  assign sat  = sat_r;
  assign prod = prod_r;

endmodule

/* src/vau_sqrt.sv */
// ----------------------------------------------------------------------------
// vau_sqrt: pipelined integer square root
// Floor square root of a 64-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module vau_sqrt
  import vau_pkg::*;
(
  input  logic              clk,
  input  logic [RAD_W-1:0]  rad,
  output logic [DATA_W-1:0] root
);

  localparam int REM_W = DATA_W + 3;

  logic [RAD_W-1:0]  n_r    [SQRT_LAT];
  logic [REM_W-1:0]  rem_r  [SQRT_LAT];
  logic [DATA_W-1:0] root_r [SQRT_LAT];

  for (genvar j = 0; j < SQRT_LAT; j++) begin : g_step
    logic [RAD_W-1:0]  n_in;
    logic [REM_W-1:0]  rem_in;
    logic [DATA_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [DATA_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign n_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    always_comb begin
      rem_sh = {rem_in[REM_W-3:0], n_in[RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_in[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_in[DATA_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      n_r[j]    <= n_in << 2;
      rem_r[j]  <= rem_nxt;
      root_r[j] <= root_nxt;
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule

/* src/vau_div.sv */
// ----------------------------------------------------------------------------
// vau_div: pipelined fixed-point divider
// Signed (num * 2^FRAC_BITS) / den truncated toward zero and saturated to
// 32 bits, one quotient bit per stage. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module vau_div
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic signed [DATA_W-1:0] num,
  input  logic        [DATA_W-1:0] den_mag,
  input  logic                     den_neg,
  output logic signed [DATA_W-1:0] quo,
  output div_flags_t               flags
);

  localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

  logic [DATA_W-1:0] num_mag;
  logic [RAD_W-1:0]  nm;
  logic [RAD_W-1:0]  nm0_r;
  logic [DATA_W-1:0] den0_r;
  logic              neg0_r;
  logic              ovf0_r;
  logic              dz0_r;

  logic [DATA_W:0]   rem_r [DIV_STEPS];
  logic [DATA_W-1:0] low_r [DIV_STEPS];
  logic [DATA_W-1:0] q_r   [DIV_STEPS];
  logic [DATA_W-1:0] den_r [DIV_STEPS];
  logic              neg_r [DIV_STEPS];
  logic              ovf_r [DIV_STEPS];
  logic              dz_r  [DIV_STEPS];

  logic [DATA_W-1:0] qm;
  logic              over;
  logic [DATA_W-1:0] quo_nxt;
  div_flags_t        flags_nxt;
  logic [DATA_W-1:0] quo_r;
  div_flags_t        flags_r;

  always_comb begin
    num_mag = num[DATA_W-1] ? -num : num;
    nm      = {{DATA_W{1'b0}}, num_mag} << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    nm0_r  <= nm;
    den0_r <= den_mag;
    neg0_r <= num[DATA_W-1] ^ den_neg;
    ovf0_r <= nm >= {den_mag, {DATA_W{1'b0}}};
    dz0_r  <= den_mag == '0;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DATA_W:0]   rem_in;
    logic [DATA_W-1:0] low_in;
    logic [DATA_W-1:0] q_in;
    logic [DATA_W-1:0] den_in;
    logic              neg_in;
    logic              ovf_in;
    logic              dz_in;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_nxt;
    logic [DATA_W-1:0] q_nxt;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, nm0_r[RAD_W-1:DATA_W]};
      assign low_in = nm0_r[DATA_W-1:0];
      assign q_in   = '0;
      assign den_in = den0_r;
      assign neg_in = neg0_r;
      assign ovf_in = ovf0_r;
      assign dz_in  = dz0_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign neg_in = neg_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign dz_in  = dz_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_in[DATA_W-1:0], low_in[DATA_W-1]};
      if (rem_sh >= {1'b0, den_in}) begin
        rem_nxt = rem_sh - {1'b0, den_in};
        q_nxt   = {q_in[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_in[DATA_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      low_r[k] <= low_in << 1;
      q_r[k]   <= q_nxt;
      den_r[k] <= den_in;
      neg_r[k] <= neg_in;
      ovf_r[k] <= ovf_in;
      dz_r[k]  <= dz_in;
    end
  end

  always_comb begin
    qm   = q_r[DIV_STEPS-1];
    over = ovf_r[DIV_STEPS-1] ||
           (neg_r[DIV_STEPS-1] ? (qm > MINV) : qm[DATA_W-1]);
    flags_nxt.dz  = dz_r[DIV_STEPS-1];
    flags_nxt.sat = 1'b0;
    if (dz_r[DIV_STEPS-1]) begin
      quo_nxt = '0;
    end else if (over) begin
      flags_nxt.sat = 1'b1;
      quo_nxt       = neg_r[DIV_STEPS-1] ? MINV : MAXV;
    end else begin
      quo_nxt = neg_r[DIV_STEPS-1] ? -qm : qm;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    flags_r <= flags_nxt;
  end

  assign quo   = quo_r;
  assign flags = flags_r;

endmodule

/* src/vector3_arith_unit.sv */
// ----------------------------------------------------------------------------
// vector3_arith_unit: three-component Q16.16 vector arithmetic unit
// Vector and scalar add, subtract, multiply and divide, compare, magnitude
// and normalize, with saturation and divide-by-zero flags.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low.
// busy is always low: the unit is a fixed pipeline and takes one item every
// clock cycle, back to back, for every request type.
// Each item gives one result on the out_ ports, shown for exactly one cycle
// with out_valid high. Results leave in the order the items came in. The
// latency is the same for all request types and is set by the 32-stage
// square root followed by the 34-stage divider, which normalize chains one
// after the other.
// Three component lanes work side by side; merge stages sum the squares
// for the square root and a final stage picks the result for the request.
// The receiver cannot stall the unit, so results are never held back.
// Reset clears all valid bits; items in flight are dropped and no result
// appears until a new item has gone through the pipeline.
// ----------------------------------------------------------------------------
module vector3_arith_unit
  import vau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic        [3:0]        in_req_type,
  input  logic signed [DATA_W-1:0] in_a_x,
  input  logic signed [DATA_W-1:0] in_a_y,
  input  logic signed [DATA_W-1:0] in_a_z,
  input  logic signed [DATA_W-1:0] in_b_x,
  input  logic signed [DATA_W-1:0] in_b_y,
  input  logic signed [DATA_W-1:0] in_b_z,
  input  logic signed [DATA_W-1:0] in_scalar,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_res_x,
  output logic signed [DATA_W-1:0] out_res_y,
  output logic signed [DATA_W-1:0] out_res_z,
  output logic                     out_cmp_true,
  output logic                     out_div_zero,
  output logic                     out_saturated
);

  localparam logic [DATA_W-1:0] MAXV = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MINV = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [3:0]                   op;
    logic                         cmp;
    logic [LANES-1:0][DATA_W-1:0] a;
    logic [LANES-1:0][DATA_W-1:0] den_mag;
    logic [LANES-1:0]             den_neg;
    logic [LANES-1:0][DATA_W-1:0] lres;
    logic [LANES-1:0]             lsat;
    logic [DATA_W-1:0]            mag;
  } rec_t;

  logic [LANES-1:0][DATA_W-1:0] in_a;
  logic [LANES-1:0][DATA_W-1:0] in_b;
  logic [LANES-1:0][DATA_W-1:0] opnd;
  lane_op_t                     kind;
  logic                         eq;
  rec_t                         rec0;
  rec_t                         rec_r [REC_N];
  logic [REC_N-1:0]             vld_r;

  logic [DATA_W-1:0]   lres [LANES];
  logic [LANES-1:0]    lsat;
  logic [RAD_W-1:0]    prod [LANES];
  logic [RAD_W-1:0]    sum01_r;
  logic [RAD_W-1:0]    p2_r;
  logic [RAD_W-1:0]    tot_r;
  logic [DATA_W-1:0]   root;

  logic [DATA_W-1:0]   dq   [LANES];
  div_flags_t          dfl  [LANES];
  logic [DATA_W-1:0]   dden [LANES];
  logic [LANES-1:0]    dneg;

  rec_t                rf;
  logic [LANES-1:0][DATA_W-1:0] res_nxt;
  logic                cmp_nxt;
  logic                dz_nxt;
  logic                sat_nxt;
  logic [LANES-1:0][DATA_W-1:0] res_r;
  logic                cmp_r;
  logic                dz_r;
  logic                sat_r;
  logic                out_valid_r;

  assign busy = 1'b0;

  assign in_a = {in_a_z, in_a_y, in_a_x};
  assign in_b = {in_b_z, in_b_y, in_b_x};

  always_comb begin
    case (in_req_type) inside
      REQ_VADD, REQ_SADD: kind = LOP_ADD;
      REQ_VSUB, REQ_SSUB: kind = LOP_SUB;
      default:            kind = LOP_MUL;
    endcase
    eq = in_a == in_b;
    rec0         = '0;
    rec0.op      = in_req_type;
    rec0.cmp     = (in_req_type == REQ_EQ) ? eq : ((in_req_type == REQ_NE) ? !eq : 1'b0);
    rec0.a       = in_a;
    for (int i = 0; i < LANES; i++) begin
      if (in_req_type <= REQ_VDIV) begin
        opnd[i] = in_b[i];
      end else if (in_req_type <= REQ_SDIV) begin
        opnd[i] = in_scalar;
      end else begin
        opnd[i] = in_a[i];
      end
      rec0.den_neg[i] = opnd[i][DATA_W-1];
      rec0.den_mag[i] = opnd[i][DATA_W-1] ? -opnd[i] : opnd[i];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vau_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .kind (kind),
      .a    (in_a[i]),
      .opnd (opnd[i]),
      .res  (lres[i]),
      .sat  (lsat[i]),
      .prod (prod[i])
    );
  end

  always_ff @(posedge clk) begin
    sum01_r <= prod[0] + prod[1];
    p2_r    <= prod[2];
    tot_r   <= sum01_r + p2_r;
  end

  vau_sqrt u_sqrt (
    .clk  (clk),
    .rad  (tot_r),
    .root (root)
  );

  for (genvar k = 0; k < REC_N; k++) begin : g_rec
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        rec_r[k] <= rec0;
      end
    end else if (k == LANE_LAT) begin : g_lres
      rec_t rec_in;
      always_comb begin
        rec_in      = rec_r[k-1];
        rec_in.lres = {lres[2], lres[1], lres[0]};
        rec_in.lsat = lsat;
      end
      always_ff @(posedge clk) begin
        rec_r[k] <= rec_in;
      end
    end else if (k == SQ_AT + 1) begin : g_mag
      rec_t rec_in;
      always_comb begin
        rec_in     = rec_r[k-1];
        rec_in.mag = root;
      end
      always_ff @(posedge clk) begin
        rec_r[k] <= rec_in;
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        rec_r[k] <= rec_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[REC_N-2:0], start & ~busy};
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_div
    assign dden[i] = (rec_r[SQ_AT].op == REQ_NORM) ? root : rec_r[SQ_AT].den_mag[i];
    assign dneg[i] = (rec_r[SQ_AT].op == REQ_NORM) ? 1'b0 : rec_r[SQ_AT].den_neg[i];

    vau_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .num     (rec_r[SQ_AT].a[i]),
      .den_mag (dden[i]),
      .den_neg (dneg[i]),
      .quo     (dq[i]),
      .flags   (dfl[i])
    );
  end

  always_comb begin
    rf      = rec_r[DIV_AT];
    res_nxt = '0;
    cmp_nxt = 1'b0;
    dz_nxt  = 1'b0;
    sat_nxt = 1'b0;
    case (rf.op) inside
      REQ_VADD, REQ_VSUB, REQ_VMUL, REQ_SADD, REQ_SSUB, REQ_SMUL: begin
        res_nxt = rf.lres;
        sat_nxt = |rf.lsat;
      end
      REQ_VDIV, REQ_SDIV, REQ_NORM: begin
        res_nxt = {dq[2], dq[1], dq[0]};
        dz_nxt  = dfl[0].dz | dfl[1].dz | dfl[2].dz;
        sat_nxt = dfl[0].sat | dfl[1].sat | dfl[2].sat;
      end
      REQ_EQ, REQ_NE: begin
        cmp_nxt = rf.cmp;
      end
      REQ_MAG: begin
        res_nxt[0] = rf.mag[DATA_W-1] ? MAXV : rf.mag;
        sat_nxt    = rf.mag[DATA_W-1];
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[DIV_AT];
    end
    res_r <= res_nxt;
    cmp_r <= cmp_nxt;
    dz_r  <= dz_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_res_x     = res_r[0];
  assign out_res_y     = res_r[1];
  assign out_res_z     = res_r[2];
  assign out_cmp_true  = cmp_r;
  assign out_div_zero  = dz_r;
  assign out_saturated = sat_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result strobe high right after reset.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, REC_N + 1))
    else $error("Result without a matching accepted item.");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmp_true |->
      !out_div_zero && !out_saturated && out_res_x == 0 && out_res_y == 0 && out_res_z == 0)
    else $error("Compare result carries flags or data.");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_res_x == MAXV || out_res_x == MINV || out_res_y == MAXV ||
      out_res_y == MINV || out_res_z == MAXV || out_res_z == MINV)
    else $error("Saturation flagged without a clamped component.");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_res_x == 0 || out_res_y == 0 || out_res_z == 0)
    else $error("Divide by zero flagged without a zero component.");

endmodule
